/* rtl/chfp_pkg.sv */
// Shared types, constants and functions for the CRC-16 hex frame packer.
`timescale 1ns / 1ps

package chfp_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'h1021;

   localparam logic [0:0] ModeStart = 1'b0;
   localparam logic [0:0] ModePayload = 1'b1;

   localparam logic [2:0] LastHeader = 3'd3;
   localparam logic [2:0] LastHeaderCrc = 3'd7;
   localparam logic [2:0] LastPayload = 3'd1;
   localparam logic [2:0] LastPayloadCrc = 3'd5;

   // One queued item: up to four bytes, sent high nibble first.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      last_idx;
      logic            with_crc;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [6:0] hex_char(input logic [3:0] v);
      logic [6:0] r;
      if (v < 4'd10) begin
         r = 7'd48 + {3'b000, v};
      end else begin
         r = 7'd55 + {3'b000, v};
      end
      return r;
   endfunction

endpackage

/* rtl/chfp_front.sv */
// Front end: accepts items, tracks the open frame and the CRC, queues byte groups.
`timescale 1ns / 1ps

module chfp_front
   import chfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_mode,
   input  logic [7:0]       req_topic,
   input  logic [7:0]       req_payload_length,
   input  logic [7:0]       req_payload_byte,
   input  queue_status_type q_status,
   output logic             q_push,
   output entry_type        q_entry
);

   logic        hdr_pending_ff, hdr_pending_in;
   logic        frame_open_ff, frame_open_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  topic_ff, topic_in;
   logic [7:0]  len_ff, len_in;

   logic        accept;
   logic [15:0] feed_crc;
   logic [7:0]  feed_byte;
   logic [15:0] crc_next;

   assign req_ready = !hdr_pending_ff && !q_status.full;
   assign accept = req_valid && req_ready;

   always_comb begin
      if (hdr_pending_ff) begin
         feed_crc = crc_ff;
         feed_byte = len_ff;
      end else if (req_mode == ModeStart) begin
         feed_crc = CrcInit;
         feed_byte = req_topic;
      end else begin
         feed_crc = crc_ff;
         feed_byte = req_payload_byte;
      end
      crc_next = crc_feed(feed_crc, feed_byte);
   end

   always_comb begin
      hdr_pending_in = hdr_pending_ff;
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      crc_in = crc_ff;
      topic_in = topic_ff;
      len_in = len_ff;
      q_push = 1'b0;
      q_entry = '0;
      if (hdr_pending_ff) begin
         q_entry.bytes = {crc_next[7:0], crc_next[15:8], len_ff, topic_ff};
         q_entry.with_crc = (len_ff == 8'd0);
         q_entry.last_idx = (len_ff == 8'd0) ? LastHeaderCrc : LastHeader;
         if (!q_status.full) begin
            q_push = 1'b1;
            hdr_pending_in = 1'b0;
            crc_in = crc_next;
            frame_open_in = (len_ff != 8'd0);
            bytes_left_in = len_ff;
         end
      end else if (accept) begin
         if (req_mode == ModeStart) begin
            // abandon any open frame; the length is fed while the header is pending
            hdr_pending_in = 1'b1;
            frame_open_in = 1'b0;
            crc_in = crc_next;
            topic_in = req_topic;
            len_in = req_payload_length;
         end else if (frame_open_ff) begin
            q_push = 1'b1;
            q_entry.bytes = {8'h00, crc_next[7:0], crc_next[15:8], req_payload_byte};
            q_entry.with_crc = (bytes_left_ff == 8'd1);
            q_entry.last_idx = (bytes_left_ff == 8'd1) ? LastPayloadCrc : LastPayload;
            crc_in = crc_next;
            bytes_left_in = bytes_left_ff - 8'd1;
            frame_open_in = (bytes_left_ff != 8'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pending_ff <= 1'b0;
         frame_open_ff <= 1'b0;
         bytes_left_ff <= 8'd0;
         crc_ff <= CrcInit;
      end else begin
         hdr_pending_ff <= hdr_pending_in;
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
         crc_ff <= crc_in;
      end
      topic_ff <= topic_in;
      len_ff <= len_in;
   end

endmodule

/* rtl/chfp_queue.sv */
// Small FIFO of byte groups between the front and back ends.
`timescale 1ns / 1ps

module chfp_queue
   import chfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type status
);

   entry_type                  mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   head_ff, tail_ff;
   logic [QueueCountWidth-1:0] count_ff;
   logic                       do_push, do_pop;

   assign status.full = (count_ff == QueueCountWidth'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign head_entry = mem_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            tail_ff <= (tail_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : tail_ff + 1'b1;
         end
         if (do_pop) begin
            head_ff <= (head_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : head_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[tail_ff] <= push_entry;
      end
   end

endmodule

/* rtl/chfp_back.sv */
// Back end: turns queued byte groups into one hex character per item.
`timescale 1ns / 1ps

module chfp_back
   import chfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  entry_type        q_entry,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [6:0]       rsp_hex_char,
   output logic             rsp_frame_end
);

   entry_type  entry_ff;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic       fire, at_last;
   logic [7:0] cur_byte;
   logic [3:0] cur_nibble;

   assign rsp_valid = busy_ff;
   assign fire = busy_ff && rsp_ready;
   assign at_last = (idx_ff == entry_ff.last_idx);
   assign q_pop = (!busy_ff || (fire && at_last)) && !q_status.empty;

   assign cur_byte = entry_ff.bytes[idx_ff[2:1]];
   assign cur_nibble = idx_ff[0] ? cur_byte[3:0] : cur_byte[7:4];
   assign rsp_hex_char = hex_char(cur_nibble);
   assign rsp_frame_end = entry_ff.with_crc && at_last;

   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         idx_in = 3'd0;
      end else if (fire) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
      if (q_pop) begin
         entry_ff <= q_entry;
      end
   end

endmodule

/* rtl/crc16_hex_frame_packer.sv */
// Top level of the CRC-16 hex frame packer.
// Emits a frame as uppercase ASCII hex, one character per result item, high nibble first:
// a start item (mode 0) gives four characters for topic and length, each payload item
// (mode 1) two, and the closing CRC-16/CCITT-FALSE (over topic, length and payload) four,
// high byte first, with frame_end set on the very last one. A zero length closes the frame
// at once; a payload item with no frame open is taken and dropped; a start abandons an open
// frame. Payload items are paced by the one-character result port, as each needs two
// characters; after a start the input is held off while the front end feeds the length
// byte through its one-byte CRC stage. A four-entry queue lets input and output stall apart.
`timescale 1ns / 1ps

module crc16_hex_frame_packer
   import chfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_topic,
   input  logic [7:0] req_payload_length,
   input  logic [7:0] req_payload_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_hex_char,
   output logic       rsp_frame_end
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   entry_type        push_entry, head_entry;

   chfp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_topic          (req_topic),
      .req_payload_length (req_payload_length),
      .req_payload_byte   (req_payload_byte),
      .q_status           (q_status),
      .q_push             (q_push),
      .q_entry            (push_entry)
   );

   chfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   chfp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_entry       (head_entry),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hex_char  (rsp_hex_char),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

/* tb/crc16_hex_frame_packer_tb.sv */
// Self-checking testbench for the CRC-16 hex frame packer.
`timescale 1ns / 1ps

module crc16_hex_frame_packer_tb;
   import chfp_pkg::*;

   typedef struct packed {
      logic [6:0] ch;
      logic       fin;
   } hex_out_type;

   class hex_frame_scoreboard;
      logic [15:0] frame_crc;
      logic [7:0]  bytes_due;
      bit          in_frame;
      hex_out_type due_chars[$];
      int          errors;
      int          taken;
      int          dropped;
      int          checked;
      int          frames;

      function new();
         frame_crc = CrcInit;
         bytes_due = 8'd0;
         in_frame  = 1'b0;
      endfunction

      function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
         logic [15:0] r;
         logic        fb;
         r = c;
         for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0};
            if (fb) begin
               r = r ^ CrcPoly;
            end
         end
         return r;
      endfunction

      function logic [6:0] to_hex(logic [3:0] n);
         return (n < 4'd10) ? 7'h30 + {3'b000, n} : 7'h37 + {3'b000, n};
      endfunction

      function void push_byte(logic [7:0] b, logic last);
         due_chars.push_back('{ch: to_hex(b[7:4]), fin: 1'b0});
         due_chars.push_back('{ch: to_hex(b[3:0]), fin: last});
      endfunction

      function void close_frame();
         push_byte(frame_crc[15:8], 1'b0);
         push_byte(frame_crc[7:0], 1'b1);
         in_frame  = 1'b0;
         bytes_due = 8'd0;
      endfunction

      function void note_item(logic [0:0] mode, logic [7:0] topic, logic [7:0] len,
                              logic [7:0] pb);
         taken++;
         if (mode == ModeStart) begin
            frame_crc = crc_step(crc_step(CrcInit, topic), len);
            push_byte(topic, 1'b0);
            push_byte(len, 1'b0);
            if (len == 8'd0) begin
               close_frame();
            end else begin
               in_frame  = 1'b1;
               bytes_due = len;
            end
         end else if (!in_frame) begin
            dropped++;
         end else begin
            frame_crc = crc_step(frame_crc, pb);
            push_byte(pb, 1'b0);
            bytes_due = bytes_due - 8'd1;
            if (bytes_due == 8'd0) begin
               close_frame();
            end
         end
      endfunction

      task report(string msg);
         if (errors < 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
         end
         errors++;
      endtask

      task check_char(logic [6:0] ch, logic fin);
         hex_out_type want;
         if (due_chars.size() == 0) begin
            report($sformatf("character 0x%02h with nothing outstanding", ch));
            return;
         end
         want = due_chars.pop_front();
         checked++;
         if (ch !== want.ch) begin
            report($sformatf("hex_char 0x%02h, wanted 0x%02h", ch, want.ch));
         end
         if (fin !== want.fin) begin
            report($sformatf("frame_end %b, wanted %b", fin, want.fin));
         end
         if (want.fin) begin
            frames++;
         end
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_mode;
   logic [7:0] req_topic;
   logic [7:0] req_payload_length;
   logic [7:0] req_payload_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [6:0] rsp_hex_char;
   logic       rsp_frame_end;

   hex_frame_scoreboard sb;
   int send_idle;
   int recv_stall;
   int random_items;

   crc16_hex_frame_packer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_topic          (req_topic),
      .req_payload_length (req_payload_length),
      .req_payload_byte   (req_payload_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hex_char       (rsp_hex_char),
      .rsp_frame_end      (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_item(req_mode, req_topic, req_payload_length, req_payload_byte);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_char(rsp_hex_char, rsp_frame_end);
         end
      end
   end

   task automatic send_item(logic [0:0] mode, logic [7:0] topic, logic [7:0] len,
                            logic [7:0] pb);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_topic          <= topic;
      req_payload_length <= len;
      req_payload_byte   <= pb;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_frame(int room);
      int len;
      int body;
      int r;
      r = $urandom_range(99);
      if (r < 65) begin
         len = $urandom_range(6);
      end else if (r < 88) begin
         len = $urandom_range(24, 7);
      end else begin
         len = $urandom_range(255);
      end
      body = len;
      if (len > 24) begin
         body = $urandom_range(len - 1);
      end else if (len > 0 && $urandom_range(99) < 8) begin
         body = $urandom_range(len - 1);
      end
      if (body > room - 1) begin
         body = room - 1;
      end
      send_item(ModeStart, 8'($urandom), len[7:0], 8'($urandom));
      random_items++;
      repeat (body) begin
         send_item(ModePayload, 8'($urandom), 8'($urandom), 8'($urandom));
         random_items++;
      end
      // stray bytes after a closed frame: dropped, not counted
      if (body == len && $urandom_range(99) < 12) begin
         repeat ($urandom_range(2, 1)) begin
            send_item(ModePayload, 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      int idle_mix[4][2];
      idle_mix = '{'{0, 0}, '{48, 0}, '{0, 48}, '{38, 38}};
      sb = new();
      send_idle    = 0;
      recv_stall   = 0;
      random_items = 0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_mode           <= ModeStart;
      req_topic          <= 8'd0;
      req_payload_length <= 8'd0;
      req_payload_byte   <= 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(ModePayload, 8'h00, 8'h00, 8'h5A);
      send_item(ModeStart, 8'hFF, 8'h00, 8'h00);
      send_item(ModeStart, 8'h00, 8'h00, 8'hFF);
      send_item(ModePayload, 8'h00, 8'h00, 8'hFF);
      send_item(ModeStart, 8'hA5, 8'h02, 8'h00);
      send_item(ModePayload, 8'hFF, 8'hFF, 8'h00);
      send_item(ModePayload, 8'h00, 8'h00, 8'hFF);
      send_item(ModePayload, 8'h00, 8'h00, 8'h3C);
      send_item(ModeStart, 8'h12, 8'hFF, 8'h00);
      send_item(ModePayload, 8'h00, 8'h00, 8'h80);
      send_item(ModePayload, 8'h00, 8'h00, 8'h7F);
      send_item(ModeStart, 8'h01, 8'h01, 8'h00);
      send_item(ModePayload, 8'h00, 8'h00, 8'hC3);
      send_item(ModeStart, 8'h5A, 8'h03, 8'h00);
      send_item(ModeStart, 8'h00, 8'h00, 8'h00);
      send_item(ModeStart, 8'h34, 8'h01, 8'h00);
      send_item(ModePayload, 8'h00, 8'h00, 8'h00);
      send_item(ModeStart, 8'hC0, 8'h80, 8'h00);
      send_item(ModeStart, 8'h0F, 8'h7F, 8'h00);

      for (int p = 0; p < 4; p++) begin
         send_idle  = idle_mix[p][0];
         recv_stall = idle_mix[p][1];
         while (random_items < 88 * (p + 1)) random_frame(88 * (p + 1) - random_items);
      end
      req_valid <= 1'b0;

      while (sb.due_chars.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Took %0d items (%0d dropped outside a frame) over four idling mixes.",
               sb.taken, sb.dropped);
      $display("Checked %0d hex characters ending %0d frames.", sb.checked, sb.frames);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
